>>> hw/rtl/sapq_pkg.sv
// ----------------------------------------------------------------------------
// sapq_pkg
// Shared types and constants of the sorted array priority queue.
// ----------------------------------------------------------------------------
package sapq_pkg;

	localparam int unsigned DEPTH_DEFAULT = 8;
	localparam int unsigned DATA_W        = 32;
	localparam int unsigned OCC_W         = 4;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_FULL     = 2'd1,
		ST_REMOVED  = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HEAD,
		S_WALK,
		S_PLACE,
		S_DONE
	} fsm_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic signed [DATA_W-1:0] prio;
	} entry_t;

endpackage

>>> hw/rtl/sapq_req_if.sv
// ----------------------------------------------------------------------------
// sapq_req_if
// Request channel: insert or remove words with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sapq_req_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 op;
	logic signed [sapq_pkg::DATA_W-1:0] item_value;
	logic signed [sapq_pkg::DATA_W-1:0] item_priority;

	modport source (output valid, output op, output item_value, output item_priority,
		input ready);
	modport sink (input valid, input op, input item_value, input item_priority,
		output ready);
endinterface

>>> hw/rtl/sapq_rsp_if.sv
// ----------------------------------------------------------------------------
// sapq_rsp_if
// Response channel: status, removed head and occupancy with valid/ready.
// ----------------------------------------------------------------------------
interface sapq_rsp_if;
	logic                                 valid;
	logic                                 ready;
	logic [1:0]                           status;
	logic signed [sapq_pkg::DATA_W-1:0] head_value;
	logic signed [sapq_pkg::DATA_W-1:0] head_priority;
	logic [sapq_pkg::OCC_W-1:0]         occupancy;

	modport source (output valid, output status, output head_value,
		output head_priority, output occupancy, input ready);
	modport sink (input valid, input status, input head_value,
		input head_priority, input occupancy, output ready);
endinterface

>>> hw/rtl/sorted_array_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_array_priority_queue
// Bounded priority queue of DEPTH entries kept sorted by ascending priority
// number in one single-port-write, single-port-read memory used as a ring.
// A remove reads the head entry and advances the head pointer. An insert
// walks from the tail toward the head, one memory read and one write per
// cycle, moving each entry with a larger priority number one place back.
// Inserts into an empty queue, rejected inserts and removes from an empty
// queue skip the walk and go straight to the done state.
// One word is worked on at a time, and a finished result waits in an
// output register while the next word is accepted.
// ----------------------------------------------------------------------------
module sorted_array_priority_queue #(
	parameter int unsigned DEPTH = sapq_pkg::DEPTH_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	sapq_req_if.sink   req,
	sapq_rsp_if.source rsp
);
	import sapq_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	fsm_t            state_q, state_d;
	logic [AW-1:0]   head_q, head_d;
	logic [AW-1:0]   j_q, j_d;
	logic [CW-1:0]   cnt_q, cnt_d;
	entry_t          item_q, item_d;
	status_t         res_status_q, res_status_d;
	entry_t          res_head_q, res_head_d;

	logic            rsp_valid_q;
	status_t         rsp_status_q;
	entry_t          rsp_head_q;
	logic [CW-1:0]   rsp_cnt_q;

	entry_t          mem [DEPTH];
	entry_t          rd_data_q;
	logic            rd_en;
	logic [AW-1:0]   rd_lidx, rd_addr;
	logic            wr_en;
	logic [AW-1:0]   wr_lidx, wr_addr;
	entry_t          wr_data;
	logic [AW:0]     rd_sum, wr_sum, head_sum;

	// logical to physical index in the ring
	always_comb begin
		rd_sum   = {1'b0, head_q} + {1'b0, rd_lidx};
		wr_sum   = {1'b0, head_q} + {1'b0, wr_lidx};
		head_sum = {1'b0, head_q} + (AW+1)'(1);
		rd_addr  = (rd_sum >= (AW+1)'(DEPTH)) ? AW'(rd_sum - (AW+1)'(DEPTH)) : AW'(rd_sum);
		wr_addr  = (wr_sum >= (AW+1)'(DEPTH)) ? AW'(wr_sum - (AW+1)'(DEPTH)) : AW'(wr_sum);
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign req.ready = (state_q == S_IDLE);

	always_comb begin
		state_d      = state_q;
		head_d       = head_q;
		j_d          = j_q;
		cnt_d        = cnt_q;
		item_d       = item_q;
		res_status_d = res_status_q;
		res_head_d   = res_head_q;
		rd_en        = 1'b0;
		rd_lidx      = '0;
		wr_en        = 1'b0;
		wr_lidx      = j_q;
		wr_data      = item_q;
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					item_d     = '{value: req.item_value, prio: req.item_priority};
					res_head_d = '0;
					if (req.op == OP_REMOVE) begin
						if (cnt_q == '0) begin
							res_status_d = ST_EMPTY;
							state_d      = S_DONE;
						end else begin
							rd_en   = 1'b1;
							state_d = S_HEAD;
						end
					end else if (cnt_q == CW'(DEPTH)) begin
						res_status_d = ST_FULL;
						state_d      = S_DONE;
					end else if (cnt_q == '0) begin
						wr_en        = 1'b1;
						wr_lidx      = '0;
						wr_data      = '{value: req.item_value, prio: req.item_priority};
						cnt_d        = cnt_q + CW'(1);
						res_status_d = ST_INSERTED;
						state_d      = S_DONE;
					end else begin
						j_d     = AW'(cnt_q);
						rd_en   = 1'b1;
						rd_lidx = AW'(cnt_q - CW'(1));
						state_d = S_WALK;
					end
				end
			end
			S_HEAD: begin
				res_head_d   = rd_data_q;
				res_status_d = ST_REMOVED;
				head_d       = (head_sum >= (AW+1)'(DEPTH)) ? '0 : AW'(head_sum);
				cnt_d        = cnt_q - CW'(1);
				state_d      = S_DONE;
			end
			S_WALK: begin
				wr_en = 1'b1;
				if (item_q.prio < rd_data_q.prio) begin
					wr_data = rd_data_q;
					j_d     = j_q - AW'(1);
					if (j_q == AW'(1)) begin
						state_d = S_PLACE;
					end else begin
						rd_en   = 1'b1;
						rd_lidx = j_q - AW'(2);
					end
				end else begin
					cnt_d        = cnt_q + CW'(1);
					res_status_d = ST_INSERTED;
					state_d      = S_DONE;
				end
			end
			S_PLACE: begin
				wr_en        = 1'b1;
				cnt_d        = cnt_q + CW'(1);
				res_status_d = ST_INSERTED;
				state_d      = S_DONE;
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			cnt_q   <= cnt_d;
			if (state_q == S_DONE && (!rsp_valid_q || rsp.ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		j_q          <= j_d;
		item_q       <= item_d;
		res_status_q <= res_status_d;
		res_head_q   <= res_head_d;
		if (state_q == S_DONE && (!rsp_valid_q || rsp.ready)) begin
			rsp_status_q <= res_status_q;
			rsp_head_q   <= res_head_q;
			rsp_cnt_q    <= cnt_q;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = rsp_status_q;
	assign rsp.head_value    = rsp_head_q.value;
	assign rsp.head_priority = rsp_head_q.prio;
	assign rsp.occupancy     = OCC_W'(rsp_cnt_q);

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK && rd_en) |-> (rd_addr != wr_addr))
		else $error("walk reads the entry it writes");

	a_walk_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && state_d == S_WALK) |-> (cnt_q != '0 && cnt_q != CW'(DEPTH)))
		else $error("insert walk started on empty or full queue");

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sorted array priority queue. A directed table
// covers empty removes, full inserts, extreme values and priorities and ties.
// A random run of inserts and removes follows, with shifting insert/remove
// mixes and priority ranges. Every response word is checked against a
// local model or a literal table row, with random gaps on both channels.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import sapq_pkg::*;

	localparam int unsigned QUEUE_DEPTH = DEPTH_DEFAULT;
	localparam int          N_DIRECTED  = 24;
	localparam int          N_RANDOM    = 400;
	localparam int          STALL_LIMIT = 2000;
	localparam int          DRAIN_WAIT  = QUEUE_DEPTH + 12;

	localparam logic signed [DATA_W-1:0] S_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] S_MAX = 32'sh7fff_ffff;

	typedef struct packed {
		status_t                  status;
		logic signed [DATA_W-1:0] head_value;
		logic signed [DATA_W-1:0] head_priority;
		logic [OCC_W-1:0]         occupancy;
	} queue_result_t;

	typedef struct packed {
		logic                     op;
		logic signed [DATA_W-1:0] value;
		logic signed [DATA_W-1:0] prio;
		logic                     literal;
		queue_result_t            want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	sapq_req_if req_ch ();
	sapq_rsp_if rsp_ch ();

	sorted_array_priority_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// sorted copy of the queue contents
	logic signed [DATA_W-1:0] sorted_values [QUEUE_DEPTH];
	logic signed [DATA_W-1:0] sorted_prios  [QUEUE_DEPTH];
	int unsigned              stored_count;

	queue_result_t expected_results [$];
	queue_result_t oldest_result;
	int unsigned   fail_count;
	int unsigned   stall_cycles;
	bit            no_idle;

	stim_row_t directed_rows [N_DIRECTED] = '{
		'{OP_REMOVE, 32'sd0, 32'sd0, 1'b1, '{ST_EMPTY, 32'sd0, 32'sd0, 4'd0}},
		'{OP_INSERT, S_MAX, 32'sd0, 1'b1, '{ST_INSERTED, 32'sd0, 32'sd0, 4'd1}},
		'{OP_REMOVE, 32'sd0, 32'sd0, 1'b1, '{ST_REMOVED, S_MAX, 32'sd0, 4'd0}},
		'{OP_INSERT, S_MIN, S_MAX, 1'b0, '{ST_INSERTED, 32'sd0, 32'sd0, 4'd0}},
		'{OP_INSERT, 32'sd1, S_MIN, 1'b0, '{ST_INSERTED, 32'sd0, 32'sd0, 4'd0}},
		'{OP_INSERT, 32'sd2, 32'sd0, 1'b0, '{ST_INSERTED, 32'sd0, 32'sd0, 4'd0}},
		'{OP_INSERT, 32'sd3, 32'sd0, 1'b0, '{ST_INSERTED, 32'sd0, 32'sd0, 4'd0}},
		'{OP_INSERT, -32'sd1, -32'sd1, 1'b0, '{ST_INSERTED, 32'sd0, 32'sd0, 4'd0}},
		'{OP_INSERT, 32'sd0, S_MAX, 1'b0, '{ST_INSERTED, 32'sd0, 32'sd0, 4'd0}},
		'{OP_INSERT, 32'sd5, S_MIN, 1'b0, '{ST_INSERTED, 32'sd0, 32'sd0, 4'd0}},
		'{OP_INSERT, 32'sd6, 32'sd1, 1'b1, '{ST_INSERTED, 32'sd0, 32'sd0, 4'd8}},
		'{OP_INSERT, 32'sd9, 32'sd0, 1'b1, '{ST_FULL, 32'sd0, 32'sd0, 4'd8}},
		'{OP_INSERT, 32'sd9, S_MIN, 1'b1, '{ST_FULL, 32'sd0, 32'sd0, 4'd8}},
		'{OP_REMOVE, S_MAX, S_MAX, 1'b0, '{ST_INSERTED, 32'sd0, 32'sd0, 4'd0}},
		'{OP_REMOVE, 32'sd0, 32'sd0, 1'b0, '{ST_INSERTED, 32'sd0, 32'sd0, 4'd0}},
		'{OP_REMOVE, -32'sd1, -32'sd1, 1'b0, '{ST_INSERTED, 32'sd0, 32'sd0, 4'd0}},
		'{OP_REMOVE, 32'sd0, 32'sd0, 1'b0, '{ST_INSERTED, 32'sd0, 32'sd0, 4'd0}},
		'{OP_REMOVE, 32'sd0, 32'sd0, 1'b0, '{ST_INSERTED, 32'sd0, 32'sd0, 4'd0}},
		'{OP_REMOVE, 32'sd0, 32'sd0, 1'b0, '{ST_INSERTED, 32'sd0, 32'sd0, 4'd0}},
		'{OP_REMOVE, 32'sd0, 32'sd0, 1'b0, '{ST_INSERTED, 32'sd0, 32'sd0, 4'd0}},
		'{OP_REMOVE, 32'sd0, 32'sd0, 1'b0, '{ST_INSERTED, 32'sd0, 32'sd0, 4'd0}},
		'{OP_REMOVE, S_MIN, S_MIN, 1'b1, '{ST_EMPTY, 32'sd0, 32'sd0, 4'd0}},
		'{OP_INSERT, -32'sd1, -32'sd1, 1'b0, '{ST_INSERTED, 32'sd0, 32'sd0, 4'd0}},
		'{OP_REMOVE, 32'sd0, 32'sd0, 1'b0, '{ST_INSERTED, 32'sd0, 32'sd0, 4'd0}}
	};

	function automatic queue_result_t predict_queue_op(input logic op,
		input logic signed [DATA_W-1:0] value, input logic signed [DATA_W-1:0] prio);
		queue_result_t res;
		int unsigned   j;
		res = '{ST_INSERTED, 32'sd0, 32'sd0, 4'd0};
		if (op == OP_INSERT) begin
			if (stored_count >= QUEUE_DEPTH) begin
				res.status = ST_FULL;
			end else begin
				j = stored_count;
				while (j > 0 && prio < sorted_prios[j-1]) begin
					sorted_values[j] = sorted_values[j-1];
					sorted_prios[j]  = sorted_prios[j-1];
					j--;
				end
				sorted_values[j] = value;
				sorted_prios[j]  = prio;
				stored_count++;
				res.status = ST_INSERTED;
			end
		end else begin
			if (stored_count == 0) begin
				res.status = ST_EMPTY;
			end else begin
				res.head_value    = sorted_values[0];
				res.head_priority = sorted_prios[0];
				for (j = 1; j < stored_count; j++) begin
					sorted_values[j-1] = sorted_values[j];
					sorted_prios[j-1]  = sorted_prios[j];
				end
				stored_count--;
				res.status = ST_REMOVED;
			end
		end
		res.occupancy = stored_count[OCC_W-1:0];
		return res;
	endfunction

	task automatic send_word(input logic op, input logic signed [DATA_W-1:0] value,
		input logic signed [DATA_W-1:0] prio, input logic literal,
		input queue_result_t want);
		queue_result_t predicted;
		if (!no_idle) begin
			while ($urandom_range(0, 99) < 31) begin
				@(negedge clk);
				req_ch.valid <= 1'b0;
			end
		end
		@(negedge clk);
		req_ch.valid         <= 1'b1;
		req_ch.op            <= op;
		req_ch.item_value    <= value;
		req_ch.item_priority <= prio;
		do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
		predicted = predict_queue_op(op, value, prio);
		expected_results.push_back(literal ? want : predicted);
	endtask

	always @(negedge clk) begin
		rsp_ch.ready <= no_idle || ($urandom_range(0, 99) >= 31);
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected word status %0d value %0d priority %0d occ %0d",
					$time, rsp_ch.status, rsp_ch.head_value, rsp_ch.head_priority,
					rsp_ch.occupancy);
				fail_count++;
			end else begin
				oldest_result = expected_results.pop_front();
				if (rsp_ch.status !== oldest_result.status) begin
					$display("%0t: status expected %0d actual %0d", $time,
						oldest_result.status, rsp_ch.status);
					fail_count++;
				end
				if (rsp_ch.head_value !== oldest_result.head_value) begin
					$display("%0t: head_value expected %0d actual %0d", $time,
						oldest_result.head_value, rsp_ch.head_value);
					fail_count++;
				end
				if (rsp_ch.head_priority !== oldest_result.head_priority) begin
					$display("%0t: head_priority expected %0d actual %0d", $time,
						oldest_result.head_priority, rsp_ch.head_priority);
					fail_count++;
				end
				if (rsp_ch.occupancy !== oldest_result.occupancy) begin
					$display("%0t: occupancy expected %0d actual %0d", $time,
						oldest_result.occupancy, rsp_ch.occupancy);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		logic                     op;
		logic signed [DATA_W-1:0] value;
		logic signed [DATA_W-1:0] prio;
		int unsigned              insert_pct;
		queue_result_t            none;
		none                 = '{ST_INSERTED, 32'sd0, 32'sd0, 4'd0};
		stored_count         = 0;
		fail_count           = 0;
		stall_cycles         = 0;
		no_idle              = 1'b0;
		arst_n               = 1'b0;
		req_ch.valid         = 1'b0;
		req_ch.op            = OP_INSERT;
		req_ch.item_value    = '0;
		req_ch.item_priority = '0;
		rsp_ch.ready         = 1'b0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			sorted_values[i] = '0;
			sorted_prios[i]  = '0;
		end
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i]) begin
			send_word(directed_rows[i].op, directed_rows[i].value, directed_rows[i].prio,
				directed_rows[i].literal, directed_rows[i].want);
		end

		for (int i = 0; i < N_RANDOM; i++) begin
			// insert/remove mix changes every 40 words to sweep fill levels
			case ((i / 40) % 4)
				0: insert_pct = 75;
				1: insert_pct = 25;
				2: insert_pct = 50;
				default: insert_pct = 90;
			endcase
			no_idle = (i >= 180 && i < 260);
			op      = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
			value   = $urandom;
			case ($urandom_range(0, 3))
				0: prio = $urandom_range(0, 3);
				1: begin
					case ($urandom_range(0, 3))
						0: prio = S_MIN;
						1: prio = S_MAX;
						2: prio = -32'sd1;
						default: prio = 32'sd0;
					endcase
				end
				default: prio = $urandom;
			endcase
			send_word(op, value, prio, 1'b0, none);
		end
		no_idle = 1'b0;
		@(negedge clk);
		req_ch.valid <= 1'b0;

		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/sapq_pkg.sv
hw/rtl/sapq_req_if.sv
hw/rtl/sapq_rsp_if.sv
hw/rtl/sorted_array_priority_queue.sv
sim/testbench.sv
